/* rtl/core/sgi_pkg.sv */
// shared status codes, stage counts and side-band type for the segment intersection unit
package sgi_pkg;

  // status codes carried with each result
  localparam logic [1:0] ST_HIT        = 2'd0;
  localparam logic [1:0] ST_PARALLEL   = 2'd1;
  localparam logic [1:0] ST_OUT_FIRST  = 2'd2;
  localparam logic [1:0] ST_OUT_SECOND = 2'd3;

  // register stages ahead of the divider chain
  localparam int unsigned FRONT_STAGES = 5;

  // field widths on the stream ports
  localparam int unsigned FIELD_W = 32;

  // side-band info that rides along the divider chain
  typedef struct packed {
    logic [1:0] status;
    logic       neg_x;
    logic       neg_y;
  } side_t;

endpackage

/* rtl/core/sgi_front.sv */
// front pipeline: deltas, cross products, sign fold and range classification
module sgi_front #(
  parameter int unsigned W = 32
) (
  input  logic                   clk_i,
  input  logic [4:0]             en_i,
  input  logic [W-1:0]           x1_i,
  input  logic [W-1:0]           y1_i,
  input  logic [W-1:0]           x2_i,
  input  logic [W-1:0]           y2_i,
  input  logic [W-1:0]           x3_i,
  input  logic [W-1:0]           y3_i,
  input  logic [W-1:0]           x4_i,
  input  logic [W-1:0]           y4_i,
  output logic [2*W+1:0]         na_o,
  output logic [2*W+1:0]         den_o,
  output logic [W:0]             magx_o,
  output logic [W:0]             magy_o,
  output logic [W-1:0]           x1_o,
  output logic [W-1:0]           y1_o,
  output sgi_pkg::side_t         side_o
);

  localparam int unsigned DW = W + 1;
  localparam int unsigned MW = 2 * DW;
  localparam int unsigned PW = 2 * W + 3;
  localparam int unsigned NW = 2 * W + 2;

  // stage 0: sign-extend and form the six differences
  logic signed [DW-1:0] dx_q, dy_q, ex_q, ey_q, ox_q, oy_q;
  logic [W-1:0]         x1_0_q, y1_0_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      dx_q   <= $signed({x2_i[W-1], x2_i}) - $signed({x1_i[W-1], x1_i});
      dy_q   <= $signed({y2_i[W-1], y2_i}) - $signed({y1_i[W-1], y1_i});
      ex_q   <= $signed({x4_i[W-1], x4_i}) - $signed({x3_i[W-1], x3_i});
      ey_q   <= $signed({y4_i[W-1], y4_i}) - $signed({y3_i[W-1], y3_i});
      ox_q   <= $signed({x1_i[W-1], x1_i}) - $signed({x3_i[W-1], x3_i});
      oy_q   <= $signed({y1_i[W-1], y1_i}) - $signed({y3_i[W-1], y3_i});
      x1_0_q <= x1_i;
      y1_0_q <= y1_i;
    end
  end

  // stage 1: six exact products
  logic signed [MW-1:0] p_eydx_q, p_exdy_q, p_exoy_q, p_eyox_q, p_dxoy_q, p_dyox_q;
  logic signed [DW-1:0] dx1_q, dy1_q;
  logic [W-1:0]         x1_1_q, y1_1_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p_eydx_q <= ey_q * dx_q;
      p_exdy_q <= ex_q * dy_q;
      p_exoy_q <= ex_q * oy_q;
      p_eyox_q <= ey_q * ox_q;
      p_dxoy_q <= dx_q * oy_q;
      p_dyox_q <= dy_q * ox_q;
      dx1_q    <= dx_q;
      dy1_q    <= dy_q;
      x1_1_q   <= x1_0_q;
      y1_1_q   <= y1_0_q;
    end
  end

  // stage 2: denominator and both numerators
  logic signed [PW-1:0] den2_q, na2_q, nb2_q;
  logic signed [DW-1:0] dx2_q, dy2_q;
  logic [W-1:0]         x1_2_q, y1_2_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      den2_q <= $signed({p_eydx_q[MW-1], p_eydx_q}) - $signed({p_exdy_q[MW-1], p_exdy_q});
      na2_q  <= $signed({p_exoy_q[MW-1], p_exoy_q}) - $signed({p_eyox_q[MW-1], p_eyox_q});
      nb2_q  <= $signed({p_dxoy_q[MW-1], p_dxoy_q}) - $signed({p_dyox_q[MW-1], p_dyox_q});
      dx2_q  <= dx1_q;
      dy2_q  <= dy1_q;
      x1_2_q <= x1_1_q;
      y1_2_q <= y1_1_q;
    end
  end

  // stage 3: fold the sign of the denominator, take delta magnitudes
  logic signed [PW-1:0] den3_q, na3_q, nb3_q;
  logic                 den_zero3_q;
  logic [DW-1:0]        magx3_q, magy3_q;
  logic                 negx3_q, negy3_q;
  logic [W-1:0]         x1_3_q, y1_3_q;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      den3_q      <= den2_q[PW-1] ? -den2_q : den2_q;
      na3_q       <= den2_q[PW-1] ? -na2_q  : na2_q;
      nb3_q       <= den2_q[PW-1] ? -nb2_q  : nb2_q;
      den_zero3_q <= (den2_q == '0);
      magx3_q     <= dx2_q[DW-1] ? DW'(-dx2_q) : DW'(dx2_q);
      magy3_q     <= dy2_q[DW-1] ? DW'(-dy2_q) : DW'(dy2_q);
      negx3_q     <= dx2_q[DW-1];
      negy3_q     <= dy2_q[DW-1];
      x1_3_q      <= x1_2_q;
      y1_3_q      <= y1_2_q;
    end
  end

  // stage 4: classify against the closed unit range
  logic [1:0] status_d;

  always_comb begin
    if (den_zero3_q) begin
      status_d = sgi_pkg::ST_PARALLEL;
    end else if (na3_q[PW-1] || (na3_q > den3_q)) begin
      status_d = sgi_pkg::ST_OUT_FIRST;
    end else if (nb3_q[PW-1] || (nb3_q > den3_q)) begin
      status_d = sgi_pkg::ST_OUT_SECOND;
    end else begin
      status_d = sgi_pkg::ST_HIT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      na_o         <= na3_q[NW-1:0];
      den_o        <= den3_q[NW-1:0];
      magx_o       <= magx3_q;
      magy_o       <= magy3_q;
      x1_o         <= x1_3_q;
      y1_o         <= y1_3_q;
      side_o.status <= status_d;
      side_o.neg_x  <= negx3_q;
      side_o.neg_y  <= negy3_q;
    end
  end

endmodule

/* rtl/core/sgi_div_step.sv */
// one stage of the scaled divider: takes one bit of each delta magnitude
module sgi_div_step #(
  parameter int unsigned W   = 32,
  parameter int unsigned BIT = 0
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [2*W+1:0]         na_i,
  input  logic [2*W+1:0]         den_i,
  input  logic [W:0]             magx_i,
  input  logic [W:0]             magy_i,
  input  logic [2*W+1:0]         rx_i,
  input  logic [2*W+1:0]         ry_i,
  input  logic [W:0]             qx_i,
  input  logic [W:0]             qy_i,
  input  logic [W-1:0]           x1_i,
  input  logic [W-1:0]           y1_i,
  input  sgi_pkg::side_t         side_i,
  output logic [2*W+1:0]         na_o,
  output logic [2*W+1:0]         den_o,
  output logic [W:0]             magx_o,
  output logic [W:0]             magy_o,
  output logic [2*W+1:0]         rx_o,
  output logic [2*W+1:0]         ry_o,
  output logic [W:0]             qx_o,
  output logic [W:0]             qy_o,
  output logic [W-1:0]           x1_o,
  output logic [W-1:0]           y1_o,
  output sgi_pkg::side_t         side_o
);

  localparam int unsigned DW = W + 1;
  localparam int unsigned NW = 2 * W + 2;

  // remainder doubles, adds na when the bit is set, then drops up to two den
  function automatic logic [NW+DW-1:0] step(
    input logic [NW-1:0] r,
    input logic [DW-1:0] q,
    input logic          b,
    input logic [NW-1:0] na,
    input logic [NW-1:0] den
  );
    logic [NW:0]   t;
    logic [NW:0]   d1;
    logic [NW:0]   d2;
    logic [DW-1:0] qn;
    t  = {r, 1'b0} + (b ? {1'b0, na} : '0);
    d1 = {1'b0, den};
    d2 = {den, 1'b0};
    qn = {q[DW-2:0], 1'b0};
    if (t >= d2) begin
      t  = t - d2;
      qn = qn + DW'(2);
    end else if (t >= d1) begin
      t  = t - d1;
      qn = qn + DW'(1);
    end
    return {t[NW-1:0], qn};
  endfunction

  logic [NW+DW-1:0] sx, sy;

  assign sx = step(rx_i, qx_i, magx_i[BIT], na_i, den_i);
  assign sy = step(ry_i, qy_i, magy_i[BIT], na_i, den_i);

  // stage register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_o   <= sx[NW+DW-1:DW];
      qx_o   <= sx[DW-1:0];
      ry_o   <= sy[NW+DW-1:DW];
      qy_o   <= sy[DW-1:0];
      na_o   <= na_i;
      den_o  <= den_i;
      magx_o <= magx_i;
      magy_o <= magy_i;
      x1_o   <= x1_i;
      y1_o   <= y1_i;
      side_o <= side_i;
    end
  end

endmodule

/* rtl/core/segment_intersection_unit.sv */
// top level: 2d segment intersection, fully pipelined with per-stage stall
//
// Input stream (s_axis_*): one transaction carries both segments, eight
// 32-bit signed coordinates in tdata; only the low COORD_WIDTH bits of
// each are used and sign-extended.
// Output stream (m_axis_*): one transaction per input; tuser holds the hit
// flag and the status code, tdata the intersection point (zero on a miss).
// The pipeline is made of five stages for differences, products and
// classification, one divider stage per bit of the delta magnitude
// (COORD_WIDTH + 1), and the output register. The divider chain is a
// bit-per-stage unit, so every stage holds an independent transaction, and
// throughput is one transaction per cycle unless the receiver stalls.
// Each stage carries its own valid bit and advances when the next stage
// moves or it is empty, so bubbles close up while the receiver stalls and
// s_axis_tready only drops once every stage holds a transaction.
// Reset clears all valid bits; no result is presented until new input.
module segment_intersection_unit #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y (32 bits each)
  input  logic [255:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // point_x [31:0], point_y [63:32]
  output logic [63:0]  m_axis_tdata_o,
  // hit [0], status [2:1]
  output logic [2:0]   m_axis_tuser_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned DW = W + 1;
  localparam int unsigned NW = 2 * W + 2;
  localparam int unsigned FS = sgi_pkg::FRONT_STAGES;
  localparam int unsigned N  = FS + DW + 1;
  localparam int unsigned FW = sgi_pkg::FIELD_W;

  // stage valid bits and advance enables
  logic [N-1:0] v_q;
  logic [N-1:0] en;

  assign en[N-1] = !v_q[N-1] || m_axis_tready_i;
  for (genvar k = 0; k < N - 1; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? s_axis_tvalid_i : v_q[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  assign s_axis_tready_o = en[0];

  // front stages
  logic [NW-1:0]   na_a   [DW+1];
  logic [NW-1:0]   den_a  [DW+1];
  logic [DW-1:0]   magx_a [DW+1];
  logic [DW-1:0]   magy_a [DW+1];
  logic [NW-1:0]   rx_a   [DW+1];
  logic [NW-1:0]   ry_a   [DW+1];
  logic [DW-1:0]   qx_a   [DW+1];
  logic [DW-1:0]   qy_a   [DW+1];
  logic [W-1:0]    x1_a   [DW+1];
  logic [W-1:0]    y1_a   [DW+1];
  sgi_pkg::side_t  side_a [DW+1];

  sgi_front #(.W(W)) u_front (
    .clk_i  (clk_i),
    .en_i   (en[FS-1:0]),
    .x1_i   (s_axis_tdata_i[0*FW +: W]),
    .y1_i   (s_axis_tdata_i[1*FW +: W]),
    .x2_i   (s_axis_tdata_i[2*FW +: W]),
    .y2_i   (s_axis_tdata_i[3*FW +: W]),
    .x3_i   (s_axis_tdata_i[4*FW +: W]),
    .y3_i   (s_axis_tdata_i[5*FW +: W]),
    .x4_i   (s_axis_tdata_i[6*FW +: W]),
    .y4_i   (s_axis_tdata_i[7*FW +: W]),
    .na_o   (na_a[0]),
    .den_o  (den_a[0]),
    .magx_o (magx_a[0]),
    .magy_o (magy_a[0]),
    .x1_o   (x1_a[0]),
    .y1_o   (y1_a[0]),
    .side_o (side_a[0])
  );

  assign rx_a[0] = '0;
  assign ry_a[0] = '0;
  assign qx_a[0] = '0;
  assign qy_a[0] = '0;

  // divider chain, most significant magnitude bit first
  for (genvar j = 0; j < DW; j++) begin : g_div
    sgi_div_step #(.W(W), .BIT(DW - 1 - j)) u_step (
      .clk_i  (clk_i),
      .en_i   (en[FS + j]),
      .na_i   (na_a[j]),
      .den_i  (den_a[j]),
      .magx_i (magx_a[j]),
      .magy_i (magy_a[j]),
      .rx_i   (rx_a[j]),
      .ry_i   (ry_a[j]),
      .qx_i   (qx_a[j]),
      .qy_i   (qy_a[j]),
      .x1_i   (x1_a[j]),
      .y1_i   (y1_a[j]),
      .side_i (side_a[j]),
      .na_o   (na_a[j+1]),
      .den_o  (den_a[j+1]),
      .magx_o (magx_a[j+1]),
      .magy_o (magy_a[j+1]),
      .rx_o   (rx_a[j+1]),
      .ry_o   (ry_a[j+1]),
      .qx_o   (qx_a[j+1]),
      .qy_o   (qy_a[j+1]),
      .x1_o   (x1_a[j+1]),
      .y1_o   (y1_a[j+1]),
      .side_o (side_a[j+1])
    );
  end

  // point = start + signed offset, zero on a miss
  sgi_pkg::side_t  side_f;
  logic [W+1:0]    offx, offy, sumx, sumy;
  logic            hit_d;
  logic [63:0]     tdata_d;

  assign side_f = side_a[DW];
  assign hit_d  = (side_f.status == sgi_pkg::ST_HIT);
  assign offx   = side_f.neg_x ? -{1'b0, qx_a[DW]} : {1'b0, qx_a[DW]};
  assign offy   = side_f.neg_y ? -{1'b0, qy_a[DW]} : {1'b0, qy_a[DW]};
  assign sumx   = {{2{x1_a[DW][W-1]}}, x1_a[DW]} + offx;
  assign sumy   = {{2{y1_a[DW][W-1]}}, y1_a[DW]} + offy;

  always_comb begin
    tdata_d = '0;
    if (hit_d) begin
      tdata_d[FW-1:0]    = FW'($signed(sumx[W-1:0]));
      tdata_d[2*FW-1:FW] = FW'($signed(sumy[W-1:0]));
    end
  end

  // output register
  logic [63:0] m_tdata_q;
  logic [2:0]  m_tuser_q;

  always_ff @(posedge clk_i) begin
    if (en[N-1]) begin
      m_tdata_q <= tdata_d;
      m_tuser_q <= {side_f.status, hit_d};
    end
  end

  assign m_axis_tvalid_o = v_q[N-1];
  assign m_axis_tdata_o  = m_tdata_q;
  assign m_axis_tuser_o  = m_tuser_q;

`ifndef SYNTHESIS
  a_hit_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o[0] == (m_axis_tuser_o[2:1] == sgi_pkg::ST_HIT)))
    else $error("hit flag disagrees with status");

  a_miss_zero_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[0]) |-> (m_axis_tdata_o == '0))
    else $error("nonzero point on a miss");

  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i && (&v_q)))
    else $error("input stalled while pipeline has room");
`endif

endmodule

/* bench/tb_segment_intersection_unit.sv */
// testbench for the segment intersection unit: directed table plus random pairs
module tb_segment_intersection_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [31:0] coord_t;

  typedef struct {
    coord_t c[8];   // x1 y1 x2 y2 x3 y3 x4 y4
  } seg_pair_t;

  typedef struct {
    logic       hit;
    logic [1:0] status;
    coord_t     px;
    coord_t     py;
  } crossing_t;

  typedef struct {
    coord_t    c[8];
    logic      known;
    crossing_t res;
  } table_row_t;

  localparam coord_t ONE  = 32'sh0001_0000;
  localparam coord_t CMAX = 32'sh7fff_ffff;
  localparam coord_t CMIN = 32'sh8000_0000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [255:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [63:0]  m_axis_tdata_o;
  logic [2:0]   m_axis_tuser_o;

  crossing_t expected_crossings[$];
  int        mismatch_count = 0;
  int        sender_mode = 0;
  int        receiver_mode = 0;
  logic      stimulus_done = 1'b0;

  segment_intersection_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // exact intersection predictor, wide signed arithmetic
  function automatic crossing_t predict_crossing(seg_pair_t p);
    logic signed [127:0] dx, dy, ex, ey, ox, oy, den, na, nb;
    crossing_t r;
    dx = p.c[2] - p.c[0];
    dy = p.c[3] - p.c[1];
    ex = p.c[6] - p.c[4];
    ey = p.c[7] - p.c[5];
    ox = p.c[0] - p.c[4];
    oy = p.c[1] - p.c[5];
    den = ey * dx - ex * dy;
    na  = ex * oy - ey * ox;
    nb  = dx * oy - dy * ox;
    r = '{hit: 1'b0, status: sgi_pkg::ST_PARALLEL, px: '0, py: '0};
    if (den != 0) begin
      if (den < 0) begin
        den = -den;
        na  = -na;
        nb  = -nb;
      end
      if (na < 0 || na > den) begin
        r.status = sgi_pkg::ST_OUT_FIRST;
      end else if (nb < 0 || nb > den) begin
        r.status = sgi_pkg::ST_OUT_SECOND;
      end else begin
        r.hit    = 1'b1;
        r.status = sgi_pkg::ST_HIT;
        // signed division truncates toward zero
        r.px = coord_t'(p.c[0] + (na * dx) / den);
        r.py = coord_t'(p.c[1] + (na * dy) / den);
      end
    end
    return r;
  endfunction

  function automatic int draw_wait(int mode);
    if (mode == 0) return 0;
    if (mode == 1) return $urandom_range(0, 2);
    return $urandom_range(0, 16);
  endfunction

  // drive one segment pair and log its expected result on acceptance
  task automatic send_pair(seg_pair_t p, crossing_t res);
    int gap;
    gap = draw_wait(sender_mode);
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    for (int i = 0; i < 8; i++) s_axis_tdata_i[32*i +: 32] = p.c[i];
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_crossings.push_back(res);
    @(negedge clk_i);
  endtask

  function automatic coord_t small_coord();
    return coord_t'($urandom_range(0, 8 * 65536)) - 4 * ONE;
  endfunction

  // random segment pair, mixing full-range noise, small boxes, shifted parallels and forced crossings
  function automatic seg_pair_t random_pair();
    seg_pair_t p;
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 8; i++) begin
      if (kind < 2) p.c[i] = coord_t'($urandom);
      else p.c[i] = small_coord();
    end
    if (kind == 2) begin
      // parallel: second is first shifted
      p.c[4] = p.c[0] + small_coord();
      p.c[5] = p.c[1] + small_coord();
      p.c[6] = p.c[4] + (p.c[2] - p.c[0]);
      p.c[7] = p.c[5] + (p.c[3] - p.c[1]);
    end else if (kind >= 6) begin
      // crossing near the origin: endpoints on opposite sides
      p.c[0] = -coord_t'($urandom_range(1, 4 * 65536));
      p.c[2] =  coord_t'($urandom_range(1, 4 * 65536));
      p.c[5] = -coord_t'($urandom_range(1, 4 * 65536));
      p.c[7] =  coord_t'($urandom_range(1, 4 * 65536));
      p.c[1] = coord_t'($urandom_range(0, 65536)) - ONE / 2;
      p.c[3] = coord_t'($urandom_range(0, 65536)) - ONE / 2;
      p.c[4] = coord_t'($urandom_range(0, 65536)) - ONE / 2;
      p.c[6] = coord_t'($urandom_range(0, 65536)) - ONE / 2;
      if (kind == 9) begin
        // huge crossing to reach the wide end of the divider
        p.c[0] = CMIN + coord_t'($urandom_range(0, 255));
        p.c[2] = CMAX - coord_t'($urandom_range(0, 255));
        p.c[5] = CMIN + coord_t'($urandom_range(0, 255));
        p.c[7] = CMAX - coord_t'($urandom_range(0, 255));
      end
    end
    return p;
  endfunction

  // directed rows: known result typed in, others predicted
  table_row_t directed_rows[] = '{
    // all zero: degenerate, parallel
    '{'{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{1'b0, sgi_pkg::ST_PARALLEL, 0, 0}},
    // x-shaped crossing at (1,1)
    '{'{0, 0, 2*ONE, 2*ONE, 0, 2*ONE, 2*ONE, 0}, 1'b1,
      '{1'b1, sgi_pkg::ST_HIT, ONE, ONE}},
    // touching at first start
    '{'{0, 0, ONE, 0, 0, -ONE, 0, ONE}, 1'b1, '{1'b1, sgi_pkg::ST_HIT, 0, 0}},
    // touching at first end
    '{'{0, 0, ONE, 0, ONE, -ONE, ONE, ONE}, 1'b1, '{1'b1, sgi_pkg::ST_HIT, ONE, 0}},
    // second lies beyond first end
    '{'{0, 0, ONE, 0, 2*ONE, -ONE, 2*ONE, ONE}, 1'b1,
      '{1'b0, sgi_pkg::ST_OUT_FIRST, 0, 0}},
    // first crosses the line of second outside second
    '{'{0, 0, 4*ONE, 0, ONE, ONE, ONE, 2*ONE}, 1'b1,
      '{1'b0, sgi_pkg::ST_OUT_SECOND, 0, 0}},
    // both out of range: first reported
    '{'{0, 0, ONE, 0, 3*ONE, ONE, 3*ONE, 2*ONE}, 1'b1,
      '{1'b0, sgi_pkg::ST_OUT_FIRST, 0, 0}},
    // collinear overlapping: still parallel
    '{'{0, 0, 2*ONE, 0, ONE, 0, 3*ONE, 0}, 1'b1, '{1'b0, sgi_pkg::ST_PARALLEL, 0, 0}},
    // degenerate second segment
    '{'{0, 0, ONE, ONE, ONE, 0, ONE, 0}, 1'b1, '{1'b0, sgi_pkg::ST_PARALLEL, 0, 0}},
    // coordinate extremes
    '{'{CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN}, 1'b0,
      '{1'b0, sgi_pkg::ST_HIT, 0, 0}},
    '{'{CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN}, 1'b0,
      '{1'b0, sgi_pkg::ST_HIT, 0, 0}},
    '{'{CMIN, 0, CMAX, 0, 0, CMIN, 0, CMAX}, 1'b1, '{1'b1, sgi_pkg::ST_HIT, 0, 0}},
    '{'{CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN}, 1'b1,
      '{1'b0, sgi_pkg::ST_PARALLEL, 0, 0}},
    '{'{-1, -1, 1, 1, -1, 1, 1, -1}, 1'b1, '{1'b1, sgi_pkg::ST_HIT, 0, 0}},
    // truncation toward zero with negative deltas
    '{'{0, 0, -3, -7, -2, 0, -2, -9}, 1'b0, '{1'b0, sgi_pkg::ST_HIT, 0, 0}},
    '{'{5, 3, -4, 11, 0, 0, 1, 13}, 1'b0, '{1'b0, sgi_pkg::ST_HIT, 0, 0}},
    '{'{CMIN, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX}, 1'b0,
      '{1'b0, sgi_pkg::ST_HIT, 0, 0}}
  };

  // stimulus
  initial begin
    seg_pair_t p;
    crossing_t res;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (directed_rows[i]) begin
      p.c = directed_rows[i].c;
      res = directed_rows[i].known ? directed_rows[i].res : predict_crossing(p);
      send_pair(p, res);
    end
    for (int n = 0; n < 1950; n++) begin
      if (n % 150 == 0) sender_mode = $urandom_range(0, 2);
      p = random_pair();
      send_pair(p, predict_crossing(p));
    end
    s_axis_tvalid_i = 1'b0;
    stimulus_done = 1'b1;
  end

  // receiver backpressure
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = draw_wait(receiver_mode);
      if (stall > 0) begin
        m_axis_tready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready_i = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      if ($urandom_range(0, 199) == 0) receiver_mode = $urandom_range(0, 2);
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    crossing_t want;
    crossing_t got;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got.hit    = m_axis_tuser_o[0];
      got.status = m_axis_tuser_o[2:1];
      got.px     = m_axis_tdata_o[31:0];
      got.py     = m_axis_tdata_o[63:32];
      if (expected_crossings.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result hit=%0b status=%0d x=%0d y=%0d",
                   got.hit, got.status, got.px, got.py);
      end else begin
        want = expected_crossings.pop_front();
        if (got.hit !== want.hit || got.status !== want.status ||
            got.px !== want.px || got.py !== want.py) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected hit=%0b status=%0d x=%0d y=%0d,",
                     want.hit, want.status, want.px, want.py,
                     " got hit=%0b status=%0d x=%0d y=%0d",
                     got.hit, got.status, got.px, got.py);
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stimulus_done);
    while (expected_crossings.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0 && expected_crossings.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/sgi_pkg.sv
rtl/core/sgi_front.sv
rtl/core/sgi_div_step.sv
rtl/core/segment_intersection_unit.sv
bench/tb_segment_intersection_unit.sv
